// ----- sv/wfha_pkg.sv -----
package wfha_pkg;

  localparam int FIELD_W          = 16;
  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_HEADER_BYTES = 24;
  localparam int DEF_ADDR_BITS    = 16;
  localparam logic [FIELD_W-1:0] ARENA_RESET = 16'hFFFF;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] RSP_DONE     = 2'd0;
  localparam logic [1:0] RSP_NO_SPACE = 2'd1;
  localparam logic [1:0] RSP_NO_ADDR  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE,
    S_FIN1,
    S_FIN2,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic move;
    logic fin1;
    logic fin2;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic op_free;
    logic fail;
    logic mv_none;
    logic mv_done;
    logic out_free;
  } stat_t;

endpackage

// ----- sv/wfha_ctrl.sv -----
module wfha_ctrl import wfha_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        priority if (stat_i.fail) state_d = S_DONE;
        else if (stat_i.mv_none) state_d = stat_i.op_free ? S_DONE : S_FIN1;
        else state_d = S_MOVE;
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
        if (stat_i.mv_done) state_d = stat_i.op_free ? S_DONE : S_FIN1;
      end
      S_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.fin2 = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- sv/wfha_dp.sv -----
module wfha_dp import wfha_pkg::*; #(
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [FIELD_W-1:0] cfg_data_i,
  input  logic               operation_i,
  input  logic [FIELD_W-1:0] request_size_i,
  input  logic [FIELD_W-1:0] free_address_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [FIELD_W-1:0] payload_address_o,
  input  cmd_t               cmd_i,
  output stat_t              stat_o
);

  localparam int AW = ADDR_BITS;
  localparam int IW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = 2 * AW + 1;
  localparam int WW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;
  localparam logic [WW-1:0] HDR_W = WW'(HEADER_BYTES);
  localparam logic [AW-1:0] HDR_A = AW'(HEADER_BYTES);
  localparam logic [FIELD_W-1:0] TWO_HDR = FIELD_W'(2 * HEADER_BYTES);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

  logic [EW-1:0] mem [MAX_BLOCKS];

  logic               op_q;
  logic [FIELD_W-1:0] req_q, where_q;
  logic [FIELD_W-1:0] arena_q;
  logic               init_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      ptr_q;
  logic               rvld_q, rd_zero_q;
  logic [IW-1:0]      ridx_q;
  logic [EW-1:0]      rdata_q;

  logic          found_q;
  logic [IW-1:0] best_idx_q;
  logic [AW-1:0] best_start_q, best_len_q;
  logic          match_q;
  logic [IW-1:0] mi_q;
  logic [AW-1:0] cur_start_q, cur_len_q;
  logic          prev_free_q, last_free_q, nxt_free_q;
  logic [AW-1:0] prev_start_q, prev_len_q, last_start_q, last_len_q, nxt_len_q;

  logic          mv_rd_q, mv_desc_q, mv_two_q;
  logic [IW-1:0] mv_end_q;

  logic [1:0]         res_status_q;
  logic [FIELD_W-1:0] res_addr_q;
  logic               out_valid_q;
  logic [1:0]         status_q;
  logic [FIELD_W-1:0] paddr_q;

  // entry decode, entry 0 reads as its reset value until written
  logic [AW-1:0] init_len;
  logic [AW-1:0] rd_start, rd_len;
  logic          rd_free;
  always_comb begin
    init_len = (arena_q >= TWO_HDR) ? AW'(arena_q - TWO_HDR) : '0;
    if (rd_zero_q) begin
      rd_start = '0;
      rd_len   = init_len;
      rd_free  = 1'b1;
    end else begin
      rd_start = rdata_q[EW-1 -: AW];
      rd_len   = rdata_q[AW:1];
      rd_free  = rdata_q[0];
    end
  end

  logic [WW-1:0] need, rd_pay;
  assign need   = HDR_W + WW'(req_q);
  assign rd_pay = WW'(rd_start) + HDR_W;

  // decide
  logic          alloc_fail, mr, ml;
  logic [AW-1:0] len_i, merged_l;
  logic [CW:0]   src0;
  logic [CW-1:0] drop_n;
  always_comb begin
    alloc_fail = !found_q || (WW'(best_len_q) < need) || (count_q >= MAX_C);
    mr       = ((CW'(mi_q) + CW'(1)) < count_q) && nxt_free_q;
    ml       = (mi_q != '0) && prev_free_q;
    len_i    = mr ? (cur_len_q + nxt_len_q + HDR_A) : cur_len_q;
    merged_l = prev_len_q + len_i + HDR_A;
    src0     = (CW+1)'(mi_q) + (CW+1)'(1) + (CW+1)'(mr);
    drop_n   = CW'(ml) + CW'(mr);
  end

  logic fail, mv_none;
  always_comb begin
    if (op_q == OP_FREE) begin
      fail    = !match_q;
      mv_none = (drop_n == '0) || (src0 >= (CW+1)'(count_q));
    end else begin
      fail    = alloc_fail;
      mv_none = ((CW'(best_idx_q) + CW'(1)) == count_q);
    end
  end

  logic rd_en;
  assign rd_en = (cmd_i.scan && (ptr_q < count_q)) || (cmd_i.move && mv_rd_q);

  // single write port
  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] rem_start, rem_len;
  assign rem_start = AW'(WW'(best_start_q) + need);
  assign rem_len   = AW'(WW'(best_len_q) - need);
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    priority if (cmd_i.decide && op_q == OP_FREE && match_q) begin
      we = 1'b1;
      if (ml) begin
        waddr = mi_q - IW'(1);
        wdata = {prev_start_q, merged_l, 1'b1};
      end else begin
        waddr = mi_q;
        wdata = {cur_start_q, len_i, 1'b1};
      end
    end else if (cmd_i.move && rvld_q) begin
      we    = 1'b1;
      waddr = mv_desc_q ? (ridx_q + IW'(1)) : (ridx_q - (mv_two_q ? IW'(2) : IW'(1)));
      wdata = {rd_start, rd_len, rd_free};
    end else if (cmd_i.fin1) begin
      we    = 1'b1;
      waddr = best_idx_q + IW'(1);
      wdata = {rem_start, rem_len, 1'b1};
    end else if (cmd_i.fin2) begin
      we    = 1'b1;
      waddr = best_idx_q;
      wdata = {best_start_q, AW'(req_q), 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata_q <= mem[ptr_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q     <= ARENA_RESET;
      init_q      <= 1'b1;
      count_q     <= CW'(1);
      ptr_q       <= '0;
      rvld_q      <= 1'b0;
      rd_zero_q   <= 1'b0;
      found_q     <= 1'b0;
      match_q     <= 1'b0;
      mv_rd_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        arena_q <= cfg_data_i;
        init_q  <= 1'b1;
        count_q <= CW'(1);
      end else if (we && waddr == '0) begin
        init_q <= 1'b0;
      end
      rvld_q <= rd_en;
      if (rd_en) rd_zero_q <= init_q && (ptr_q == '0);
      if (cmd_i.load) begin
        ptr_q   <= '0;
        found_q <= 1'b0;
        match_q <= 1'b0;
      end
      if (cmd_i.scan && rd_en) ptr_q <= ptr_q + CW'(1);
      if (cmd_i.scan && rvld_q) begin
        if (rd_free && (!found_q || rd_len > best_len_q)) found_q <= 1'b1;
        if (!match_q && rd_pay == WW'(where_q)) match_q <= 1'b1;
      end
      if (cmd_i.decide && !fail) begin
        mv_rd_q <= !mv_none;
        if (op_q == OP_FREE) begin
          count_q <= count_q - drop_n;
          ptr_q   <= src0[CW-1:0];
        end else begin
          ptr_q <= count_q - CW'(1);
        end
      end
      if (cmd_i.move && mv_rd_q) begin
        if (ptr_q[IW-1:0] == mv_end_q) mv_rd_q <= 1'b0;
        else ptr_q <= mv_desc_q ? (ptr_q - CW'(1)) : (ptr_q + CW'(1));
      end
      if (cmd_i.fin2) count_q <= count_q + CW'(1);
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      req_q   <= request_size_i;
      where_q <= free_address_i;
    end
    if (rd_en) ridx_q <= ptr_q[IW-1:0];
    if (cmd_i.scan && rvld_q) begin
      if (rd_free && (!found_q || rd_len > best_len_q)) begin
        best_idx_q   <= ridx_q;
        best_start_q <= rd_start;
        best_len_q   <= rd_len;
      end
      if (!match_q && rd_pay == WW'(where_q)) begin
        mi_q         <= ridx_q;
        cur_start_q  <= rd_start;
        cur_len_q    <= rd_len;
        prev_free_q  <= last_free_q;
        prev_start_q <= last_start_q;
        prev_len_q   <= last_len_q;
      end
      if (match_q && ridx_q == mi_q + IW'(1)) begin
        nxt_free_q <= rd_free;
        nxt_len_q  <= rd_len;
      end
      last_free_q  <= rd_free;
      last_start_q <= rd_start;
      last_len_q   <= rd_len;
    end
    if (cmd_i.decide) begin
      res_status_q <= fail ? ((op_q == OP_FREE) ? RSP_NO_ADDR : RSP_NO_SPACE) : RSP_DONE;
      res_addr_q   <= '0;
      if (op_q == OP_FREE) begin
        mv_end_q  <= IW'(count_q - CW'(1));
        mv_desc_q <= 1'b0;
        mv_two_q  <= ml && mr;
      end else begin
        mv_end_q  <= best_idx_q + IW'(1);
        mv_desc_q <= 1'b1;
        mv_two_q  <= 1'b0;
      end
    end
    if (cmd_i.fin2) res_addr_q <= FIELD_W'(WW'(best_start_q) + HDR_W);
    if (cmd_i.emit) begin
      status_q <= res_status_q;
      paddr_q  <= res_addr_q;
    end
  end

  always_comb begin
    stat_o.scan_done = cmd_i.scan && rvld_q && (CW'(ridx_q) == count_q - CW'(1));
    stat_o.op_free   = (op_q == OP_FREE);
    stat_o.fail      = fail;
    stat_o.mv_none   = mv_none;
    stat_o.mv_done   = cmd_i.move && rvld_q && (ridx_q == mv_end_q);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign payload_address_o = paddr_q;

endmodule

// ----- sv/worst_fit_heap_allocator_unit.sv -----
// sequence: a request scans every table entry, then is decided; a failed request or a free
// with no table shift responds from there, a shift moves the later entries, and an allocate
// then writes the split remainder and the allocated block before its response is loaded
// throughput: one request at a time, the next accept in the cycle after the response is loaded
// reset: async active low, arena 65535 and one free block, no clearing pass needed
// an arena write re-initializes the table
module worst_fit_heap_allocator_unit import wfha_pkg::*; #(
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // arena size register
  input  logic               cfg_we_i,
  input  logic [FIELD_W-1:0] cfg_data_i,
  // request beat
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [FIELD_W-1:0] request_size_i,
  input  logic [FIELD_W-1:0] free_address_i,
  // response beat
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [FIELD_W-1:0] payload_address_o
);

  // controller sequences scan, decide, table shift and split writes
  cmd_t  cmd;
  stat_t stat;

  wfha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath holds the block memory, scan trackers and the response register
  wfha_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (operation_i),
    .request_size_i    (request_size_i),
    .free_address_i    (free_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .payload_address_o (payload_address_o),
    .cmd_i             (cmd),
    .stat_o            (stat)
  );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import wfha_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXB = DEF_MAX_BLOCKS;
  localparam int HDR  = DEF_HEADER_BYTES;
  localparam int DRAIN_CYCLES = 2 * MAXB + 20;  // worst shift latency plus margin

  typedef struct {
    logic               op;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] addr;
  } heap_req_t;

  typedef struct {
    logic [1:0]         status;
    logic [FIELD_W-1:0] addr;
  } heap_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [FIELD_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic operation_i = OP_ALLOC;
  logic [FIELD_W-1:0] request_size_i = '0;
  logic [FIELD_W-1:0] free_address_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [FIELD_W-1:0] payload_address_o;

  worst_fit_heap_allocator_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .request_size_i    (request_size_i),
    .free_address_i    (free_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .payload_address_o (payload_address_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // shadow copy of the block table
  int arena_sz;
  int blk_start [MAXB];
  int blk_len [MAXB];
  bit blk_free [MAXB];
  int blk_cnt;
  logic [FIELD_W-1:0] live_q [$];   // payload offsets believed to be allocated

  heap_req_t pend_q [$];            // beats waiting for the driver
  heap_rsp_t rsp_q [$];             // responses still owed by the block
  int fails = 0;
  int long_hold_ask = 0;
  int long_hold_done = 0;

  function automatic void heap_init(input int bytes);
    arena_sz = bytes;
    for (int i = 0; i < MAXB; i++) begin
      blk_start[i] = 0;
      blk_len[i] = 0;
      blk_free[i] = 1'b0;
    end
    // tiny arena saturates to a zero-length free block
    blk_len[0] = (bytes >= 2 * HDR) ? bytes - 2 * HDR : 0;
    blk_free[0] = 1'b1;
    blk_cnt = 1;
    live_q.delete();
  endfunction

  function automatic void drop_block(input int k);
    for (int j = k; j + 1 < blk_cnt; j++) begin
      blk_start[j] = blk_start[j+1];
      blk_len[j] = blk_len[j+1];
      blk_free[j] = blk_free[j+1];
    end
    blk_cnt--;
  endfunction

  function automatic heap_rsp_t heap_alloc(input int req);
    heap_rsp_t r;
    int best;
    bit found;
    int need;
    best = 0;
    found = 0;
    r.status = RSP_NO_SPACE;
    r.addr = '0;
    // first of the largest free blocks
    for (int i = 0; i < blk_cnt; i++) begin
      if (blk_free[i] && (!found || blk_len[i] > blk_len[best])) begin
        best = i;
        found = 1;
      end
    end
    need = HDR + req;
    if (!found || blk_len[best] < need || blk_cnt >= MAXB) return r;
    for (int j = blk_cnt; j > best + 1; j--) begin
      blk_start[j] = blk_start[j-1];
      blk_len[j] = blk_len[j-1];
      blk_free[j] = blk_free[j-1];
    end
    // split always leaves a free remainder, maybe of length zero
    blk_start[best+1] = blk_start[best] + need;
    blk_len[best+1] = blk_len[best] - need;
    blk_free[best+1] = 1'b1;
    blk_len[best] = req;
    blk_free[best] = 1'b0;
    blk_cnt++;
    r.status = RSP_DONE;
    r.addr = FIELD_W'(blk_start[best] + HDR);
    live_q.push_back(r.addr);
    return r;
  endfunction

  function automatic heap_rsp_t heap_release(input int where);
    heap_rsp_t r;
    r.status = RSP_NO_ADDR;
    r.addr = '0;
    for (int i = 0; i < blk_cnt; i++) begin
      if (blk_start[i] + HDR == where) begin
        blk_free[i] = 1'b1;
        // merge right first, then left
        if (i + 1 < blk_cnt && blk_free[i+1]) begin
          blk_len[i] += blk_len[i+1] + HDR;
          drop_block(i + 1);
        end
        if (i > 0 && blk_free[i-1]) begin
          blk_len[i-1] += blk_len[i] + HDR;
          drop_block(i);
        end
        r.status = RSP_DONE;
        return r;
      end
    end
    return r;
  endfunction

  // short gaps mostly, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // request driver: one beat in flight, held until accepted
  int send_gap = 0;
  always @(posedge clk_i) begin
    heap_req_t nxt;
    if (in_valid_i && in_ready_o) begin
      if (operation_i == OP_ALLOC) rsp_q.push_back(heap_alloc(int'(request_size_i)));
      else rsp_q.push_back(heap_release(int'(free_address_i)));
    end
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pend_q.size() > 0) begin
        nxt = pend_q.pop_front();
        operation_i <= nxt.op;
        request_size_i <= nxt.size;
        free_address_i <= nxt.addr;
        in_valid_i <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // response monitor and ready generator
  int recv_gap = 0;
  always @(posedge clk_i) begin
    heap_rsp_t want;
    if (out_valid_o && out_ready_i) begin
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected response beat status %0d addr %0d",
                 $time, status_o, payload_address_o);
        fails++;
      end else begin
        want = rsp_q.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          fails++;
        end
        if (payload_address_o !== want.addr) begin
          $display("%0t: payload_address expected %0d actual %0d",
                   $time, want.addr, payload_address_o);
          fails++;
        end
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (long_hold_done != long_hold_ask) begin
      // long hold-off so the block backs up and stalls its input
      long_hold_done <= long_hold_ask;
      recv_gap <= 600;
      out_ready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
    end
  end

  task automatic queue_beat(input logic op, input int size, input int addr);
    heap_req_t q;
    q.op = op;
    q.size = FIELD_W'(size);
    q.addr = FIELD_W'(addr);
    pend_q.push_back(q);
  endtask

  // sender pauses until every response is back and the block is quiet
  // checked mid-cycle so driver and monitor updates have settled
  task automatic drain();
    while (pend_q.size() > 0 || in_valid_i || rsp_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_arena(input int bytes);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= FIELD_W'(bytes);
    heap_init(bytes);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random mix of mostly well-formed traffic, fed a few beats ahead
  task automatic random_beats(input int n, input int alloc_pct);
    int pick;
    int k;
    for (int i = 0; i < n; i++) begin
      while (pend_q.size() >= 3) @(posedge clk_i);
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        case ($urandom_range(0, 19))
          0: queue_beat(OP_ALLOC, 0, $urandom);
          1: queue_beat(OP_ALLOC, 16'hFFFF, $urandom);
          2: queue_beat(OP_ALLOC, $urandom_range(0, 65535), $urandom);
          default: queue_beat(OP_ALLOC, $urandom_range(0, arena_sz / 6 + 1), $urandom);
        endcase
      end else if (pick < 95 && live_q.size() > 0) begin
        k = $urandom_range(0, live_q.size() - 1);
        queue_beat(OP_FREE, $urandom, live_q[k]);
        // keep some stale entries around so double frees happen
        if ($urandom_range(0, 4) != 0) live_q.delete(k);
      end else begin
        queue_beat(OP_FREE, $urandom, $urandom_range(0, 65535));
      end
    end
  endtask

  initial begin
    heap_init(int'(ARENA_RESET));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed on the reset arena: exact fit, oversize, double free, unknown offsets
    queue_beat(OP_ALLOC, 0, 0);
    queue_beat(OP_ALLOC, 16'hFFFF, 0);
    queue_beat(OP_ALLOC, 65535 - 2 * HDR - HDR - HDR, 16'hFFFF);
    queue_beat(OP_ALLOC, 0, 0);
    queue_beat(OP_FREE, 0, HDR);
    queue_beat(OP_FREE, 16'hFFFF, HDR);
    queue_beat(OP_FREE, 0, 2 * HDR + HDR);
    queue_beat(OP_FREE, 0, 1);
    queue_beat(OP_FREE, 0, 16'hFFFF);
    queue_beat(OP_FREE, 0, 0);
    queue_beat(OP_ALLOC, 100, 0);
    drain();

    // smallest legal arena, tiny ones that saturate, then a small exact fit
    write_arena(64);
    queue_beat(OP_ALLOC, 0, 0);
    queue_beat(OP_FREE, 0, HDR);
    drain();
    write_arena(0);
    queue_beat(OP_ALLOC, 0, 0);
    drain();
    write_arena(40);
    queue_beat(OP_ALLOC, 0, 0);
    queue_beat(OP_FREE, 0, HDR);
    drain();
    write_arena(100);
    queue_beat(OP_ALLOC, 100 - 2 * HDR - HDR, 0);
    queue_beat(OP_ALLOC, 0, 0);
    queue_beat(OP_FREE, 0, HDR);
    drain();

    // fill the table past its last entry, then churn
    write_arena(65535);
    for (int i = 0; i < MAXB + 6; i++) queue_beat(OP_ALLOC, $urandom_range(0, 50), 0);
    random_beats(60, 30);
    drain();

    write_arena(1000);
    random_beats(150, 60);
    drain();

    // receiver holds off while the sender keeps offering
    write_arena(65535);
    long_hold_ask++;
    random_beats(200, 60);
    drain();

    write_arena(4000);
    random_beats(150, 55);
    drain();

    write_arena($urandom_range(64, 65535));
    random_beats(160, 65);
    drain();

    if (fails == 0) begin
      $display("PASS worst_fit_heap_allocator_unit");
    end else begin
      $display("FAIL worst_fit_heap_allocator_unit");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("FAIL worst_fit_heap_allocator_unit");
    $finish;
  end

endmodule
